>>> sv/mrrp_pkg.sv
// Package with the shared types, codes and CRC function of the Modbus RTU response parser.
`timescale 1ns / 1ps

package mrrp_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REGISTER = 8'd1;

	localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h70;
	localparam logic [15:0] FIRST_REGISTER_RST = 16'h0000;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;
	localparam int         FUNC_EXC_BIT      = 7;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ADDR  = 3'd1;
	localparam logic [2:0] ST_EXC   = 3'd2;
	localparam logic [2:0] ST_FUNC  = 3'd3;
	localparam logic [2:0] ST_SHORT = 3'd4;
	localparam logic [2:0] ST_CRC   = 3'd5;

	localparam logic KIND_REG    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       abort;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] reg_address;
		logic [15:0] reg_value;
		logic [2:0]  status;
		logic [7:0]  exception_code;
		logic [6:0]  reg_count;
	} res_t;

	// Reflected CRC-16 update over one byte, least significant bit first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> sv/mrrp_ifs.sv
// Channel interfaces of the Modbus RTU response parser: byte input, result output, config writes.
`timescale 1ns / 1ps

interface mrrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       abort;

	modport source (output valid, output rx_byte, output abort, input ready);
	modport sink (input valid, input rx_byte, input abort, output ready);
endinterface

interface mrrp_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] reg_address;
	logic [15:0] reg_value;
	logic [2:0]  status;
	logic [7:0]  exception_code;
	logic [6:0]  reg_count;

	modport source (output valid, output kind, output reg_address, output reg_value,
		output status, output exception_code, output reg_count, input ready);
	modport sink (input valid, input kind, input reg_address, input reg_value,
		input status, input exception_code, input reg_count, output ready);
endinterface

interface mrrp_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/mrrp_frame.sv
// Frame tracker: per-byte state machine, running CRC and result formation.
`timescale 1ns / 1ps

module mrrp_frame (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  mrrp_pkg::in_item_t item,
	input  logic [7:0]      device_address,
	input  logic [15:0]     first_register,
	output logic            res_valid,
	output mrrp_pkg::res_t  res
);
	import mrrp_pkg::*;

	localparam logic [2:0] PH_ADDR   = 3'd0;
	localparam logic [2:0] PH_FUNC   = 3'd1;
	localparam logic [2:0] PH_COUNT  = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_CRC_LO = 3'd4;
	localparam logic [2:0] PH_CRC_HI = 3'd5;
	localparam logic [2:0] PH_EXC    = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  idx_q, idx_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [2:0]  err_q, err_d;
	logic [7:0]  exc_q, exc_d;

	logic [15:0] crc_next;
	logic [7:0]  idx_inc;
	logic [15:0] rx_crc;
	logic [2:0]  final_st;

	assign crc_next = crc_feed(crc_q, item.rx_byte);
	assign idx_inc  = idx_q + 8'd1;
	assign rx_crc   = {item.rx_byte, crc_lo_q};
	assign final_st = (err_q == ST_OK && rx_crc != crc_q) ? ST_CRC : err_q;

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		held_d    = held_q;
		crc_lo_d  = crc_lo_q;
		err_d     = err_q;
		exc_d     = exc_q;
		res_valid = 1'b0;
		res       = '0;

		if (item.abort) begin
			phase_d  = PH_ADDR;
			crc_d    = CRC_INIT;
			cnt_d    = '0;
			idx_d    = '0;
			held_d   = '0;
			crc_lo_d = '0;
			err_d    = ST_OK;
			exc_d    = '0;
		end else begin
			case (phase_q)
				PH_ADDR: begin
					crc_d    = crc_feed(CRC_INIT, item.rx_byte);
					cnt_d    = '0;
					idx_d    = '0;
					held_d   = '0;
					crc_lo_d = '0;
					exc_d    = '0;
					err_d    = (item.rx_byte != device_address) ? ST_ADDR : ST_OK;
					phase_d  = PH_FUNC;
				end
				PH_FUNC: begin
					crc_d = crc_next;
					if (item.rx_byte[FUNC_EXC_BIT]) begin
						if (err_q == ST_OK) begin
							err_d = ST_EXC;
						end
						phase_d = PH_EXC;
					end else begin
						if (err_q == ST_OK && item.rx_byte != FUNC_READ_HOLDING
								&& item.rx_byte != FUNC_READ_INPUT) begin
							err_d = ST_FUNC;
						end
						phase_d = PH_COUNT;
					end
				end
				PH_EXC: begin
					crc_d   = crc_next;
					exc_d   = item.rx_byte;
					phase_d = PH_CRC_LO;
				end
				PH_COUNT: begin
					crc_d = crc_next;
					cnt_d = item.rx_byte;
					idx_d = '0;
					if (err_q == ST_OK && item.rx_byte < 8'd2) begin
						err_d = ST_SHORT;
					end
					phase_d = (item.rx_byte == 8'd0) ? PH_CRC_LO : PH_DATA;
				end
				PH_DATA: begin
					crc_d = crc_next;
					if (!idx_q[0]) begin
						held_d = item.rx_byte;
					end else begin
						res_valid       = 1'b1;
						res.kind        = KIND_REG;
						res.reg_address = first_register + {9'd0, idx_q[7:1]};
						res.reg_value   = {held_q, item.rx_byte};
						res.reg_count   = cnt_q[7:1];
					end
					idx_d = idx_inc;
					if (idx_inc == cnt_q) begin
						phase_d = PH_CRC_LO;
					end
				end
				PH_CRC_LO: begin
					crc_lo_d = item.rx_byte;
					phase_d  = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					res_valid          = 1'b1;
					res.kind           = KIND_STATUS;
					res.status         = final_st;
					res.exception_code = (final_st == ST_EXC) ? exc_q : 8'd0;
					res.reg_count      = cnt_q[7:1];
					phase_d  = PH_ADDR;
					crc_d    = CRC_INIT;
					cnt_d    = '0;
					idx_d    = '0;
					held_d   = '0;
					crc_lo_d = '0;
					err_d    = ST_OK;
					exc_d    = '0;
				end
				default: begin
					phase_d  = PH_ADDR;
					crc_d    = CRC_INIT;
					cnt_d    = '0;
					idx_d    = '0;
					held_d   = '0;
					crc_lo_d = '0;
					err_d    = ST_OK;
					exc_d    = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ADDR;
			crc_q    <= CRC_INIT;
			cnt_q    <= '0;
			idx_q    <= '0;
			held_q   <= '0;
			crc_lo_q <= '0;
			err_q    <= ST_OK;
			exc_q    <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			cnt_q    <= cnt_d;
			idx_q    <= idx_d;
			held_q   <= held_d;
			crc_lo_q <= crc_lo_d;
			err_q    <= err_d;
			exc_q    <= exc_d;
		end
	end

endmodule

>>> sv/mrrp_out_reg.sv
// Result register that holds one result transaction until the receiver takes it.
`timescale 1ns / 1ps

module mrrp_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  mrrp_pkg::res_t res,
	output logic           free,
	mrrp_out_if.source     out
);
	import mrrp_pkg::*;

	logic valid_q;
	res_t data_q;

	assign free = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= res;
		end
	end

	assign out.valid          = valid_q;
	assign out.kind           = data_q.kind;
	assign out.reg_address    = data_q.reg_address;
	assign out.reg_value      = data_q.reg_value;
	assign out.status         = data_q.status;
	assign out.exception_code = data_q.exception_code;
	assign out.reg_count      = data_q.reg_count;

endmodule

>>> sv/modbus_rtu_response_parser.sv
// Top level of the Modbus RTU read-registers response parser.
// Usage:
//   rx carries one received response byte per transaction, with an abort flag that
//   drops a partial frame and ignores the byte. res carries results: a register item
//   (kind 0) for each completed big-endian data pair, and a status item (kind 1) at
//   the final CRC byte of each frame. Register items are tentative until the status
//   item of their frame reports ok. cfg writes the expected device address (index 0)
//   and the first register address (index 1); it is always ready and should only be
//   used while no frame is in flight.
// Timing:
//   A byte accepted into the input register is framed and checked combinationally,
//   and any result it causes enters the result register once that register is free.
//   One byte per cycle is sustained while the receiver keeps up; the CRC update is an
//   unrolled eight-bit step between the input register and the frame CRC register.
//   When the receiver stalls, the result register holds its transaction; one more
//   byte waits in the input register and rx ready drops only if that byte would
//   also produce a result.
// Reset: clears both registers to their defaults (device address 0x70, first
// register 0), empties the pipeline and starts waiting for an address byte.
`timescale 1ns / 1ps

module modbus_rtu_response_parser (
	input  logic       clk,
	input  logic       arst_n,
	mrrp_in_if.sink    rx,
	mrrp_out_if.source res,
	mrrp_cfg_if.sink   cfg
);
	import mrrp_pkg::*;

	logic [7:0]  device_address_q;
	logic [15:0] first_register_q;

	logic        valid_s1;
	in_item_t    item_s1;

	logic        res_valid;
	res_t        res_d;
	logic        out_free;
	logic        adv;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DEVICE_ADDRESS_RST;
			first_register_q <= FIRST_REGISTER_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DEVICE_ADDRESS: device_address_q <= cfg.data[7:0];
				CFG_FIRST_REGISTER: first_register_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// The byte in the input register moves on unless it makes a result the
	// result register cannot take this cycle.
	assign adv      = valid_s1 && (!res_valid || out_free);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			item_s1.rx_byte <= rx.rx_byte;
			item_s1.abort   <= rx.abort;
		end
	end

	mrrp_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.item           (item_s1),
		.device_address (device_address_q),
		.first_register (first_register_q),
		.res_valid      (res_valid),
		.res            (res_d)
	);

	mrrp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && res_valid),
		.res    (res_d),
		.free   (out_free),
		.out    (res)
	);

endmodule

>>> sv/mrrp_checker.sv
// Port-level assertions for the Modbus RTU response parser, bound to its top level.
`timescale 1ns / 1ps

module mrrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_kind,
	input logic [15:0] res_reg_address,
	input logic [15:0] res_reg_value,
	input logic [2:0]  res_status,
	input logic [7:0]  res_exception_code
);
	import mrrp_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result transaction withdrawn before it was taken");

	a_status_item_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_STATUS |-> res_reg_address == 16'd0
			&& res_reg_value == 16'd0)
		else $error("status item carries register fields");

	a_reg_item_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_REG |-> res_status == ST_OK
			&& res_exception_code == 8'd0)
		else $error("register item carries status fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_status <= ST_CRC)
		else $error("status code out of range");

	a_exc_code_only_with_exc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_exception_code != 8'd0 |-> res_status == ST_EXC)
		else $error("exception code without exception status");

endmodule

bind modbus_rtu_response_parser mrrp_checker u_mrrp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_kind           (res.kind),
	.res_reg_address    (res.reg_address),
	.res_reg_value      (res.reg_value),
	.res_status         (res.status),
	.res_exception_code (res.exception_code)
);

>>> dv/modbus_rtu_response_parser_tb.sv
// Self-checking testbench of the Modbus RTU response parser, with its own frame model.
`timescale 1ns / 1ps

module modbus_rtu_response_parser_tb;
	import mrrp_pkg::*;

	typedef enum logic [2:0] {
		FR_ADDR, FR_FUNC, FR_COUNT, FR_DATA, FR_CRC_LO, FR_CRC_HI, FR_EXC
	} frame_phase_e;

	typedef enum {FILL_NONE, FILL_CRC_LO, FILL_CRC_HI} crc_fill_e;

	typedef struct {
		logic [7:0] rx_byte;
		logic       abort;
		crc_fill_e  fill;
		bit         pinned;
		res_t       want;
	} byte_row_t;

	localparam res_t NO_RES = '0;

	logic clk = 1'b0;
	logic arst_n;

	mrrp_in_if  rx_if ();
	mrrp_out_if res_if ();
	mrrp_cfg_if cfg_if ();

	modbus_rtu_response_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Configuration and frame state of the parser model.
	logic [7:0]   cf_dev;
	logic [15:0]  cf_first;
	frame_phase_e pr_phase;
	logic [15:0]  pr_crc;
	logic [7:0]   pr_len;
	logic [7:0]   pr_idx;
	logic [7:0]   pr_hi;
	logic [7:0]   pr_crc_lo;
	logic [2:0]   pr_err;
	logic [7:0]   pr_exc;

	res_t pending_frame_results [$];
	int   fail_count = 0;
	int   items_sent = 0;
	bit   rx_burst = 1'b0;
	bit   sink_burst = 1'b0;

	byte_row_t byte_table [32];

	// Bit-serial form of the reflected CRC-16: each data bit enters the feedback term.
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			r = (r[0] ^ b[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic void clear_frame();
		pr_phase  = FR_ADDR;
		pr_crc    = CRC_INIT;
		pr_len    = '0;
		pr_idx    = '0;
		pr_hi     = '0;
		pr_crc_lo = '0;
		pr_err    = ST_OK;
		pr_exc    = '0;
	endfunction

	function automatic void flag_error(input logic [2:0] code);
		if (pr_err == ST_OK) pr_err = code;
	endfunction

	function automatic res_t status_res(input logic [2:0] st, input logic [7:0] exc,
		input logic [6:0] cnt);
		res_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = st;
		r.exception_code = exc;
		r.reg_count = cnt;
		return r;
	endfunction

	function automatic string fmt_res(input res_t r);
		return $sformatf("kind=%0d addr=%h value=%h status=%0d exc=%h count=%0d",
			r.kind, r.reg_address, r.reg_value, r.status, r.exception_code, r.reg_count);
	endfunction

	function automatic void log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// Advances the frame model by one accepted byte and returns the result it causes, if any.
	task automatic predict_frame_byte(input logic [7:0] b, input logic ab, output bit got,
		output res_t r);
		logic [15:0] rx_crc;
		logic [2:0]  st;
		got = 1'b0;
		r = '0;
		if (ab) begin
			clear_frame();
			return;
		end
		case (pr_phase)
			FR_ADDR: begin
				clear_frame();
				pr_crc = crc16_step(pr_crc, b);
				if (b != cf_dev) flag_error(ST_ADDR);
				pr_phase = FR_FUNC;
			end
			FR_FUNC: begin
				pr_crc = crc16_step(pr_crc, b);
				if (b[FUNC_EXC_BIT]) begin
					flag_error(ST_EXC);
					pr_phase = FR_EXC;
				end else begin
					if (b != FUNC_READ_HOLDING && b != FUNC_READ_INPUT) flag_error(ST_FUNC);
					pr_phase = FR_COUNT;
				end
			end
			FR_EXC: begin
				pr_crc = crc16_step(pr_crc, b);
				pr_exc = b;
				pr_phase = FR_CRC_LO;
			end
			FR_COUNT: begin
				pr_crc = crc16_step(pr_crc, b);
				pr_len = b;
				pr_idx = '0;
				if (b < 8'd2) flag_error(ST_SHORT);
				pr_phase = (b == 8'd0) ? FR_CRC_LO : FR_DATA;
			end
			FR_DATA: begin
				pr_crc = crc16_step(pr_crc, b);
				if (!pr_idx[0]) begin
					pr_hi = b;
				end else begin
					r.kind = KIND_REG;
					r.reg_address = cf_first + 16'(pr_idx >> 1);
					r.reg_value = {pr_hi, b};
					r.reg_count = pr_len[7:1];
					got = 1'b1;
				end
				pr_idx = pr_idx + 8'd1;
				if (pr_idx == pr_len) pr_phase = FR_CRC_LO;
			end
			FR_CRC_LO: begin
				pr_crc_lo = b;
				pr_phase = FR_CRC_HI;
			end
			FR_CRC_HI: begin
				rx_crc = {b, pr_crc_lo};
				st = pr_err;
				if (st == ST_OK && rx_crc != pr_crc) st = ST_CRC;
				r = status_res(st, (st == ST_EXC) ? pr_exc : 8'h00, pr_len[7:1]);
				got = 1'b1;
				clear_frame();
			end
			default: begin
				clear_frame();
			end
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_byte(input logic [7:0] b, input logic ab, input bit pinned,
		input res_t want);
		int   gap;
		bit   got;
		res_t r;
		if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
		gap = rx_burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		rx_if.abort <= ab;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		predict_frame_byte(b, ab, got, r);
		if (pinned) begin
			pending_frame_results.push_back(want);
		end else if (got) begin
			pending_frame_results.push_back(r);
		end
		items_sent++;
		@(negedge clk);
	endtask

	// Mostly well-formed responses with random content; some noise, bad CRCs and aborts.
	task automatic send_random_frame(input int force_len);
		logic [7:0]  frame [$];
		logic [7:0]  fn;
		logic [15:0] c;
		int          roll;
		int          len;
		roll = $urandom_range(0, 99);
		if (force_len < 0 && roll < 8) begin
			repeat ($urandom_range(1, 6)) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0, NO_RES);
			end
			return;
		end
		frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : cf_dev);
		roll = $urandom_range(0, 99);
		if (force_len >= 0 || roll < 75) begin
			fn = $urandom_range(0, 1) ? FUNC_READ_HOLDING : FUNC_READ_INPUT;
		end else if (roll < 87) begin
			fn = 8'h80 | 8'($urandom_range(0, 127));
		end else begin
			fn = 8'($urandom_range(0, 255));
		end
		frame.push_back(fn);
		if (fn[FUNC_EXC_BIT]) begin
			frame.push_back(8'($urandom_range(0, 255)));
		end else begin
			roll = $urandom_range(0, 99);
			if (force_len >= 0) len = force_len;
			else if (roll < 5) len = 0;
			else if (roll < 10) len = 1;
			else if (roll < 80) len = $urandom_range(2, 16);
			else if (roll < 95) len = $urandom_range(17, 48);
			else len = $urandom_range(49, 254);
			frame.push_back(8'(len));
			repeat (len) frame.push_back(8'($urandom_range(0, 255)));
		end
		c = CRC_INIT;
		foreach (frame[i]) c = crc16_step(c, frame[i]);
		if ($urandom_range(0, 99) < 12) c ^= 16'($urandom_range(1, 65535));
		frame.push_back(c[7:0]);
		frame.push_back(c[15:8]);
		foreach (frame[i]) begin
			if ($urandom_range(0, 199) == 0) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_RES);
				return;
			end
			send_byte(frame[i], 1'b0, 1'b0, NO_RES);
		end
	endtask

	// Called at a falling edge with no frame in flight; writes both registers back to back.
	task automatic write_config(input logic [7:0] dev, input logic [15:0] first);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= CFG_DEVICE_ADDRESS;
		cfg_if.data <= {8'h00, dev};
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cf_dev = dev;
		@(negedge clk);
		cfg_if.index <= CFG_FIRST_REGISTER;
		cfg_if.data <= first;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cf_first = first;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Result receiver with random stalls.
	initial begin
		int stall;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		res_t seen;
		res_t want;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			seen.kind = res_if.kind;
			seen.reg_address = res_if.reg_address;
			seen.reg_value = res_if.reg_value;
			seen.status = res_if.status;
			seen.exception_code = res_if.exception_code;
			seen.reg_count = res_if.reg_count;
			if (pending_frame_results.size() == 0) begin
				log_failure({"unexpected result: ", fmt_res(seen)});
			end else begin
				want = pending_frame_results.pop_front();
				if (seen !== want) begin
					log_failure({"result mismatch: expected ", fmt_res(want), ", got ",
						fmt_res(seen)});
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [7:0] b;
		int         target;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		rx_if.abort = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		arst_n = 1'b0;
		cf_dev = DEVICE_ADDRESS_RST;
		cf_first = FIRST_REGISTER_RST;
		clear_frame();

		// Directed frames at the reset configuration. Status rows are typed in where the
		// first error decides them; the good frame takes its CRC bytes from the model.
		byte_table = '{
			'{8'hFF, 1'b1, FILL_NONE, 1'b0, NO_RES},
			// Exception response, five bytes; the wrong CRC does not matter.
			'{8'h70, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h83, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h00, 1'b0, FILL_NONE, 1'b1, status_res(ST_EXC, 8'hFF, 7'd0)},
			// Address mismatch outranks the too-short byte count.
			'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h03, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'hFF, 1'b0, FILL_NONE, 1'b1, status_res(ST_ADDR, 8'h00, 7'd0)},
			// Bad function, still framed by its odd byte count and still emitting a register.
			'{8'h70, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h7F, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h03, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h80, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h12, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h34, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h00, 1'b0, FILL_NONE, 1'b1, status_res(ST_FUNC, 8'h00, 7'd1)},
			// Byte count of one: too short, one data byte, then two CRC bytes.
			'{8'h70, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h04, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h01, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h55, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h00, 1'b0, FILL_NONE, 1'b1, status_res(ST_SHORT, 8'h00, 7'd0)},
			// Good frame with one register.
			'{8'h70, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h03, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'h02, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_RES},
			'{8'hFF, 1'b0, FILL_NONE, 1'b1,
				'{KIND_REG, 16'h0000, 16'hFFFF, ST_OK, 8'h00, 7'd1}},
			'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, NO_RES},
			'{8'h00, 1'b0, FILL_CRC_HI, 1'b1, status_res(ST_OK, 8'h00, 7'd1)}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (byte_table[i]) begin
			b = byte_table[i].rx_byte;
			if (byte_table[i].fill == FILL_CRC_LO) b = pr_crc[7:0];
			else if (byte_table[i].fill == FILL_CRC_HI) b = pr_crc[15:8];
			send_byte(b, byte_table[i].abort, byte_table[i].pinned, byte_table[i].want);
		end
		rx_if.valid <= 1'b0;

		for (int ph = 0; ph < 4; ph++) begin
			// Let the last transactions drain before the registers change.
			while (pending_frame_results.size() != 0) @(negedge clk);
			repeat (4) @(negedge clk);
			case (ph)
				0: write_config(8'h00, 16'h0000);
				1: write_config(8'hFF, 16'hFFFF);
				2: write_config(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				default: write_config(DEVICE_ADDRESS_RST, 16'hFFF8);
			endcase
			target = items_sent + 180;
			if (ph == 2) send_random_frame(255);
			while (items_sent < target) send_random_frame(-1);
			// Drop any partial frame so that no frame spans a register write.
			send_byte(8'h00, 1'b1, 1'b0, NO_RES);
			rx_if.valid <= 1'b0;
		end

		while (pending_frame_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
